// File: rtl/think_tag_stripper_macros.svh
// assertion macros shared by the think tag stripper rtl
`ifndef THINK_TAG_STRIPPER_MACROS_SVH
`define THINK_TAG_STRIPPER_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define TTS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tts assertion failed");

// next-cycle implication
`define TTS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tts assertion failed");

`endif

// File: rtl/tts_pkg.sv
// shared types, constants and tag tables for the think tag stripper
package tts_pkg;

    localparam int CNT_W     = 16;
    localparam int IDX_W     = 3;
    localparam int OPEN_LEN  = 7;
    localparam int CLOSE_LEN = 8;

    localparam logic [CNT_W-1:0] CAP_RESET = 16'd4096;
    localparam logic [7:0]       CHAR_LT   = 8'h3C;
    localparam logic [7:0]       CHAR_NL   = 8'h0A;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_BUSY
    } tts_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic emit_cand;
        logic emit_mark;
        logic advance;
        logic set_drop;
        logic finish;
        logic busy;
    } tts_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic job_last;
        logic n_zero;
        logic fits;
        logic at_final;
        logic room_last;
        logic out_free;
    } tts_status_t;

    // "<think>"
    function automatic logic [7:0] open_char(input logic [IDX_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h3C;
            3'd1:    ch = 8'h74;
            3'd2:    ch = 8'h68;
            3'd3:    ch = 8'h69;
            3'd4:    ch = 8'h6E;
            3'd5:    ch = 8'h6B;
            3'd6:    ch = 8'h3E;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "</think>"
    function automatic logic [7:0] close_char(input logic [IDX_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h3C;
            3'd1:    ch = 8'h2F;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h68;
            3'd4:    ch = 8'h69;
            3'd5:    ch = 8'h6E;
            3'd6:    ch = 8'h6B;
            3'd7:    ch = 8'h3E;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/tts_ctrl.sv
// controller state machine: sequences one input word's candidate bytes
module tts_ctrl
    import tts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  tts_status_t status,
    output logic        in_stall,
    output tts_cmd_t    cmd
);

    tts_state_t state_reg;
    tts_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_BUSY:
            begin
                cmd.busy = 1'b1;
                if (status.n_zero || !status.fits)
                begin
                    // nothing (more) fits: only an end marker may still be due
                    cmd.set_drop = !status.n_zero;
                    if (status.job_last)
                    begin
                        cmd.emit_mark = status.out_free;
                        cmd.finish    = status.out_free;
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                    end
                end
                else if (status.out_free)
                begin
                    cmd.emit_cand = 1'b1;
                    if (status.at_final || status.room_last)
                    begin
                        cmd.finish = 1'b1;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        in_stall = cmd.busy && !cmd.finish;
        cmd.load = in_valid && !in_stall;

        if (cmd.load)
        begin
            state_next = ST_BUSY;
        end
        else if (cmd.finish)
        begin
            state_next = ST_IDLE;
        end
    end

endmodule

// File: rtl/tts_dp.sv
// datapath: tag matching, candidate byte walk, byte count and output register
module tts_dp
    import tts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,
    input  logic             res_stall,
    input  tts_cmd_t         cmd,
    output tts_status_t      status,
    output logic             res_valid,
    output logic [7:0]       out_byte,
    output logic             out_valid,
    output logic             out_last,
    output logic             overflow,
    output logic [CNT_W-1:0] total_written
);

    // stream state
    logic             inside_reg;
    logic [IDX_W-1:0] tp_reg;
    logic             drop_nl_reg;
    logic [CNT_W-1:0] bw_reg;
    logic             dropped_reg;
    logic [CNT_W-1:0] cap_reg;

    // current word's job
    logic [IDX_W-1:0] job_pre_reg;
    logic             job_cur_en_reg;
    logic [7:0]       job_byte_reg;
    logic [IDX_W-1:0] job_n_reg;
    logic             job_last_reg;
    logic [IDX_W-1:0] k_reg;

    // output register
    logic             res_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_valid_reg;
    logic             out_last_reg;
    logic             overflow_reg;
    logic [CNT_W-1:0] total_reg;

    // decode of the incoming word
    logic             dec_inside;
    logic [IDX_W-1:0] dec_tp;
    logic             dec_drop;
    logic [IDX_W-1:0] dec_pre;
    logic             dec_cur;
    logic [IDX_W-1:0] dec_tail;
    logic [IDX_W-1:0] dec_n;
    logic [IDX_W-1:0] open_idx;

    logic [CNT_W-1:0] limit;
    logic [CNT_W:0]   bw_plus;
    logic [7:0]       cand_byte;
    logic [IDX_W-1:0] tail_idx;
    logic             drop_rest;

    always_comb
    begin
        dec_inside = inside_reg;
        dec_tp     = tp_reg;
        dec_drop   = drop_nl_reg;
        dec_pre    = '0;
        dec_cur    = 1'b0;
        dec_tail   = '0;
        open_idx   = (tp_reg >= IDX_W'(OPEN_LEN)) ? '0 : tp_reg;

        if (inside_reg)
        begin
            if (in_byte == close_char(tp_reg))
            begin
                if (tp_reg == IDX_W'(CLOSE_LEN - 1))
                begin
                    dec_inside = 1'b0;
                    dec_drop   = 1'b1;
                    dec_tp     = '0;
                end
                else
                begin
                    dec_tp = tp_reg + 1'b1;
                end
            end
            else
            begin
                dec_tp = (in_byte == CHAR_LT) ? IDX_W'(1) : '0;
            end
        end
        else if (drop_nl_reg && (in_byte == CHAR_NL))
        begin
            dec_drop = 1'b0;
        end
        else
        begin
            dec_drop = 1'b0;
            if (in_byte == open_char(open_idx))
            begin
                if (open_idx == IDX_W'(OPEN_LEN - 1))
                begin
                    dec_inside = 1'b1;
                    dec_tp     = '0;
                end
                else
                begin
                    dec_tp = open_idx + 1'b1;
                end
            end
            else
            begin
                // held prefix goes out, then this byte is looked at afresh
                dec_pre = open_idx;
                if (in_byte == CHAR_LT)
                begin
                    dec_tp = IDX_W'(1);
                end
                else
                begin
                    dec_tp  = '0;
                    dec_cur = 1'b1;
                end
            end
        end

        // end of stream flushes a held opening prefix
        if (in_last && !dec_inside)
        begin
            dec_tail = dec_tp;
        end

        dec_n = dec_pre + dec_tail + {{(IDX_W-1){1'b0}}, dec_cur};
    end

    // candidate k: held prefix, current byte, then end-of-stream prefix
    assign tail_idx = k_reg - job_pre_reg - {{(IDX_W-1){1'b0}}, job_cur_en_reg};

    always_comb
    begin
        if (k_reg < job_pre_reg)
        begin
            cand_byte = open_char(k_reg);
        end
        else if (job_cur_en_reg && (k_reg == job_pre_reg))
        begin
            cand_byte = job_byte_reg;
        end
        else
        begin
            cand_byte = open_char(tail_idx);
        end
    end

    assign limit   = (cap_reg == '0) ? '0 : cap_reg - 1'b1;
    assign bw_plus = {1'b0, bw_reg} + 1'b1;

    assign status.job_last  = job_last_reg;
    assign status.n_zero    = (job_n_reg == '0);
    assign status.fits      = (bw_reg < limit);
    assign status.at_final  = (k_reg == job_n_reg - 1'b1);
    assign status.room_last = (bw_plus >= {1'b0, limit});
    assign status.out_free  = !res_valid_reg || !res_stall;

    assign drop_rest = !status.at_final && status.room_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg     <= 1'b0;
            tp_reg         <= '0;
            drop_nl_reg    <= 1'b0;
            job_pre_reg    <= '0;
            job_cur_en_reg <= 1'b0;
            job_n_reg      <= '0;
            job_last_reg   <= 1'b0;
            k_reg          <= '0;
        end
        else if (cmd.load)
        begin
            inside_reg     <= in_last ? 1'b0 : dec_inside;
            tp_reg         <= in_last ? '0 : dec_tp;
            drop_nl_reg    <= in_last ? 1'b0 : dec_drop;
            job_pre_reg    <= dec_pre;
            job_cur_en_reg <= dec_cur;
            job_n_reg      <= dec_n;
            job_last_reg   <= in_last;
            k_reg          <= '0;
        end
        else if (cmd.advance)
        begin
            k_reg <= k_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            job_byte_reg <= in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg      <= '0;
            dropped_reg <= 1'b0;
        end
        else if (cmd.finish && job_last_reg)
        begin
            bw_reg      <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit_cand)
            begin
                bw_reg <= bw_plus[CNT_W-1:0];
            end
            if ((cmd.emit_cand && drop_rest) || cmd.set_drop)
            begin
                dropped_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.emit_cand || cmd.emit_mark)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_cand)
        begin
            out_byte_reg  <= cand_byte;
            out_valid_reg <= 1'b1;
            out_last_reg  <= job_last_reg && cmd.finish;
            overflow_reg  <= dropped_reg || (job_last_reg && drop_rest);
            total_reg     <= bw_plus[CNT_W-1:0];
        end
        else if (cmd.emit_mark)
        begin
            out_byte_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b1;
            overflow_reg  <= dropped_reg || !status.n_zero;
            total_reg     <= bw_reg;
        end
    end

    assign res_valid     = res_valid_reg;
    assign out_byte      = out_byte_reg;
    assign out_valid     = out_valid_reg;
    assign out_last      = out_last_reg;
    assign overflow      = overflow_reg;
    assign total_written = total_reg;

endmodule

// File: rtl/think_tag_stripper.sv
// top level of the think tag stripper: controller, datapath and checks
//
// Byte-stream filter that drops everything from "<think>" through the next
// "</think>", plus one newline right after the closing tag.
// Input channel: in_valid / in_stall carrying in_byte and in_last (last byte
// of a text). Output channel: res_valid / res_stall carrying out_byte,
// out_valid (0 for an empty end marker), out_last, overflow, total_written.
// cfg_wr_en / cfg_wr_data set the output capacity (reset 4096); at most
// capacity minus one bytes are passed per text, later ones set overflow.
// Each word holds the controller busy, and the input stalled, until its
// last result byte is emitted: plain text streams at one word per cycle
// while res_stall is low, and a failed tag match flushes the held prefix
// first. An accepted word moves the controller into its busy state, whose
// emits set the registered res_valid. The output register lets the next
// word be taken while a result waits. A stalled receiver holds the output
// register and the controller, which then stalls the input. Reset clears
// the stream state, the count and res_valid; the capacity goes back to 4096.
`include "think_tag_stripper_macros.svh"

module think_tag_stripper
    import tts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,
    // input words
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    // result words
    output logic             res_valid,
    input  logic             res_stall,
    output logic [7:0]       out_byte,
    output logic             out_valid,
    output logic             out_last,
    output logic             overflow,
    output logic [CNT_W-1:0] total_written
);

    tts_cmd_t    cmd;
    tts_status_t status;

    // sequencing of candidate bytes per word
    tts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // matching, counting and the output register
    tts_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_byte       (in_byte),
        .in_last       (in_last),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .res_stall     (res_stall),
        .cmd           (cmd),
        .status        (status),
        .res_valid     (res_valid),
        .out_byte      (out_byte),
        .out_valid     (out_valid),
        .out_last      (out_last),
        .overflow      (overflow),
        .total_written (total_written)
    );

    // a word is taken mid-job only on the cycle the job wraps up
    `TTS_ASSERT_IMP(a_load_on_finish, in_valid && !in_stall && cmd.busy, cmd.finish)
    // an end marker always closes a text
    `TTS_ASSERT_IMP(a_mark_is_last, res_valid && !out_valid, out_last)
    // a passed byte always counts itself
    `TTS_ASSERT_IMP(a_count_nonzero, res_valid && out_valid, total_written != '0)
    // whatever the controller emits shows up on the output next cycle
    `TTS_ASSERT_NXT(a_emit_shows, cmd.emit_cand || cmd.emit_mark, res_valid)

endmodule

// File: dv/think_tag_stripper_test.sv
// self-checking testbench for the think tag stripper: random streams, stalls, capacity sweeps
`timescale 1ns / 1ps

module think_tag_stripper_test;
    import tts_pkg::*;

    // clock, reset and run limits
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 11;
    localparam int SETTLE       = 16;    // cycles allowed after the last result
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int IDLE_LIMIT   = 2000;  // watchdog: cycles with no word moving
    localparam int PRINT_LIMIT  = 30;

    // the two tags, first character in the top byte
    localparam logic [8*OPEN_LEN-1:0]  OPEN_TAG  = "<think>";
    localparam logic [8*CLOSE_LEN-1:0] CLOSE_TAG = "</think>";

    // one input word as offered on the input channel
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_byte_t;

    // one result word, fields in port order
    typedef struct packed {
        logic [7:0]       ch;
        logic             valid;
        logic             last;
        logic             ovf;
        logic [CNT_W-1:0] count;
    } text_word_t;

    // kinds of stream segment the generator strings together
    typedef enum int {
        SEG_BLOCK,
        SEG_OPEN_PART,
        SEG_CLOSE_PART,
        SEG_NOISE,
        SEG_UNCLOSED,
        SEG_NEWLINE
    } seg_kind_t;

    // block ports, the inputs all known from time zero
    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             cfg_wr_en     = 1'b0;
    logic [CNT_W-1:0] cfg_wr_data   = '0;
    logic             in_valid      = 1'b0;
    logic             in_stall;
    logic [7:0]       in_byte       = 8'h00;
    logic             in_last       = 1'b0;
    logic             res_valid;
    logic             res_stall     = 1'b0;
    logic [7:0]       out_byte;
    logic             out_valid;
    logic             out_last;
    logic             overflow;
    logic [CNT_W-1:0] total_written;

    think_tag_stripper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .in_last       (in_last),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .out_byte      (out_byte),
        .out_valid     (out_valid),
        .out_last      (out_last),
        .overflow      (overflow),
        .total_written (total_written)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // words waiting to be offered, and the expected stripped text
    text_byte_t text_in_q[$];
    text_word_t stripped_q[$];
    text_word_t step_words[$];      // results of the word being predicted

    int unsigned bytes_queued = 0;
    int unsigned bytes_taken  = 0;
    int unsigned fail_count   = 0;
    int unsigned idle_cycles  = 0;

    // traffic knobs, percent of cycles
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_on        = 1'b0;
    int unsigned hold_cnt       = 0;

    // predictor state: capacity register plus per-stream filter state
    logic [CNT_W-1:0] cap_bytes  = CAP_RESET;
    logic             in_think   = 1'b0;
    int unsigned      tag_pos    = 0;
    logic             skip_nl    = 1'b0;
    logic [CNT_W-1:0] bytes_out  = '0;
    logic             lost_bytes = 1'b0;

    function automatic logic [7:0] open_at(input int unsigned i);
        return OPEN_TAG[8*(OPEN_LEN-1-i) +: 8];
    endfunction

    function automatic logic [7:0] close_at(input int unsigned i);
        return CLOSE_TAG[8*(CLOSE_LEN-1-i) +: 8];
    endfunction

    task report_mismatch(input string what);
        if (fail_count < PRINT_LIMIT)
            $display("%0t mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // write one character if there is room left, else flag the loss
    task put_char(input logic [7:0] ch);
        logic [CNT_W-1:0] room_limit;
        text_word_t       w;
        room_limit = (cap_bytes == '0) ? '0 : cap_bytes - 1'b1;
        if (bytes_out < room_limit && bytes_out != {CNT_W{1'b1}} && step_words.size() < 8)
        begin
            bytes_out = bytes_out + 1'b1;
            w.ch      = ch;
            w.valid   = 1'b1;
            w.last    = 1'b0;
            w.ovf     = lost_bytes;
            w.count   = bytes_out;
            step_words.push_back(w);
        end
        else
        begin
            lost_bytes = 1'b1;
        end
    endtask

    // release the held part of an opening tag
    task flush_prefix();
        int unsigned i;
        for (i = 0; i < tag_pos && i < OPEN_LEN; i++)
            put_char(open_at(i));
        tag_pos = 0;
    endtask

    // expected result words for one accepted input word
    task strip_byte(input logic [7:0] c, input logic last);
        text_word_t w;
        step_words.delete();
        if (in_think)
        begin
            // inside a region only the closing tag matters
            if (c == close_at(tag_pos))
            begin
                tag_pos++;
                if (tag_pos == CLOSE_LEN)
                begin
                    in_think = 1'b0;
                    skip_nl  = 1'b1;
                    tag_pos  = 0;
                end
            end
            else
            begin
                tag_pos = (c == CHAR_LT) ? 1 : 0;
            end
        end
        else if (skip_nl && c == CHAR_NL)
        begin
            skip_nl = 1'b0;
        end
        else
        begin
            skip_nl = 1'b0;
            if (tag_pos >= OPEN_LEN)
                tag_pos = 0;
            if (c == open_at(tag_pos))
            begin
                tag_pos++;
                if (tag_pos == OPEN_LEN)
                begin
                    in_think = 1'b1;
                    tag_pos  = 0;
                end
            end
            else
            begin
                // failed open match: held prefix out, then this byte looked at afresh
                flush_prefix();
                if (c == CHAR_LT)
                    tag_pos = 1;
                else
                    put_char(c);
            end
        end

        if (last)
        begin
            // a partial closing tag in a region is simply forgotten
            if (!in_think)
                flush_prefix();
            if (step_words.size() == 0)
            begin
                w.ch    = 8'h00;
                w.valid = 1'b0;
                w.last  = 1'b0;
                w.ovf   = lost_bytes;
                w.count = bytes_out;
                step_words.push_back(w);
            end
            w       = step_words.pop_back();
            w.last  = 1'b1;
            w.ovf   = lost_bytes;
            w.count = bytes_out;
            step_words.push_back(w);
            in_think   = 1'b0;
            tag_pos    = 0;
            skip_nl    = 1'b0;
            bytes_out  = '0;
            lost_bytes = 1'b0;
        end

        foreach (step_words[k])
            stripped_q.push_back(step_words[k]);
    endtask

    // ------------------------------------------------------------------
    // driver: predicts on acceptance, then offers the next word or idles
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                strip_byte(in_byte, in_last);
                bytes_taken++;
            end
            // a stalled word stays put; valid only moves when nothing is held
            if (!in_valid || !in_stall)
            begin
                if (text_in_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    text_byte_t b;
                    b = text_in_q.pop_front();
                    in_valid <= 1'b1;
                    in_byte  <= b.ch;
                    in_last  <= b.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: compares each accepted result word and drives the stall
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                text_word_t got;
                text_word_t want;
                got.ch    = out_byte;
                got.valid = out_valid;
                got.last  = out_last;
                got.ovf   = overflow;
                got.count = total_written;
                if (stripped_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word byte %h valid %b last %b",
                                              got.ch, got.valid, got.last));
                end
                else
                begin
                    want = stripped_q.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf(
                            "got %h/%b/%b/%b/%0d expected %h/%b/%b/%b/%0d",
                            got.ch, got.valid, got.last, got.ovf, got.count,
                            want.ch, want.valid, want.last, want.ovf, want.count));
                end
            end
            res_stall <= (hold_on && hold_cnt < HOLD_CYCLES) ||
                         ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    // the long hold-off counts its own cycles once armed
    always @(posedge clk)
    begin
        if (hold_on)
            hold_cnt <= hold_cnt + 1;
    end

    // watchdog: give up when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout with %0d result words outstanding", stripped_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task push_byte(input logic [7:0] ch, input logic last);
        text_byte_t b;
        b.ch   = ch;
        b.last = last;
        text_in_q.push_back(b);
        bytes_queued++;
    endtask

    task push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(s[i], 1'b0);
    endtask

    // tag characters and newlines are favored so matches start often
    function automatic logic [7:0] pick_char();
        logic [7:0] ch;
        case ($urandom_range(5, 0))
            0:       ch = open_at($urandom_range(OPEN_LEN - 1, 0));
            1:       ch = close_at($urandom_range(CLOSE_LEN - 1, 0));
            2:       ch = CHAR_NL;
            default: ch = 8'($urandom_range(255, 0));
        endcase
        return ch;
    endfunction

    task push_noise(input int unsigned n);
        repeat (n) push_byte(pick_char(), 1'b0);
    endtask

    task push_open(input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++)
            push_byte(open_at(i), 1'b0);
    endtask

    task push_close(input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++)
            push_byte(close_at(i), 1'b0);
    endtask

    // one text: well-formed regions with random content in half of the segments, some noise
    task add_stream();
        int unsigned segs;
        int unsigned r;
        seg_kind_t   kind;
        segs = $urandom_range(4, 1);
        repeat (segs)
        begin
            r    = $urandom_range(9, 0);
            kind = (r < 5) ? SEG_BLOCK : seg_kind_t'(r - 4);
            case (kind)
                SEG_BLOCK:
                begin
                    push_noise($urandom_range(3, 0));
                    push_open(OPEN_LEN);
                    push_noise($urandom_range(5, 0));
                    push_close(CLOSE_LEN);
                    if ($urandom_range(1, 0))
                        push_byte(CHAR_NL, 1'b0);
                    push_noise($urandom_range(3, 0));
                end
                SEG_OPEN_PART:
                begin
                    push_open($urandom_range(OPEN_LEN - 1, 1));
                    if ($urandom_range(1, 0))
                        push_byte(pick_char(), 1'b0);
                end
                SEG_CLOSE_PART:
                begin
                    push_close($urandom_range(CLOSE_LEN - 1, 1));
                    push_byte(pick_char(), 1'b0);
                end
                SEG_NOISE:
                    push_noise($urandom_range(6, 1));
                SEG_UNCLOSED:
                begin
                    push_open(OPEN_LEN);
                    push_noise($urandom_range(4, 0));
                end
                SEG_NEWLINE:
                    push_byte(CHAR_NL, 1'b0);
                default:
                    push_byte(pick_char(), 1'b0);
            endcase
        end
        push_byte(pick_char(), 1'b1);
    endtask

    task add_random(input int unsigned n);
        int unsigned goal;
        goal = bytes_queued + n;
        while (bytes_queued < goal)
            add_stream();
    endtask

    // everything offered, taken and answered, plus a margin for stragglers
    task wait_drained();
        while (bytes_taken != bytes_queued || stripped_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // register write only while the block is idle
    task write_capacity(input logic [CNT_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cap_bytes = value;
    endtask

    task run_phase(input logic [CNT_W-1:0] cap, input int unsigned idle_pct,
                   input int unsigned stall_pct, input int unsigned n);
        write_capacity(cap);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        add_random(n);
        wait_drained();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, at the reset capacity: failed open match, failed close match,
        // newline eaten after the region, empty end marker
        push_text("<tA<<think><</think>");
        push_byte(CHAR_NL, 1'b1);
        // byte extremes, then a held prefix flushed by the end of the text
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(CHAR_LT, 1'b0);
        push_byte("t", 1'b1);
        wait_drained();

        run_phase(16'hFFFF, 0, 0, 30);
        run_phase(16'd8, 83, 0, 30);

        // leave a text open so the next capacity lands mid-stream
        push_text("abc<th");
        wait_drained();
        run_phase(16'd1, 0, 83, 25);
        run_phase(16'd0, 34, 34, 15);

        // receiver holds off while the sender keeps offering: block fills up
        write_capacity(CAP_RESET);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_on        = 1'b1;
        add_random(30);
        wait_drained();
        hold_on        = 1'b0;

        run_phase(16'd12, 34, 34, 25);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
